// ===== hdl/line_follower_pd_drive_assert.svh =====
// Assertion macros shared by the line follower checker.
`ifndef LINE_FOLLOWER_PD_DRIVE_ASSERT_SVH
`define LINE_FOLLOWER_PD_DRIVE_ASSERT_SVH

// A property checked on every rising clock edge outside reset.
`define LFPD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// A stalled beat keeps valid high and its payload unchanged.
`define LFPD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) \
		else $error("stalled beat changed before it was taken");

`endif

// ===== hdl/lfpd_pkg.sv =====
// Shared types, constants and register codes of the line follower PD drive.
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

	localparam int NUM_SENSORS = 6;
	localparam int SAMPLE_W = 8;
	localparam int SUM_W = 11;
	localparam int MOM_W = 17;
	localparam int MAG_W = 16;
	localparam int POS_W = 8;

	localparam int LOST_BELOW = 20;
	localparam int END_ABOVE = 750;
	localparam int GAIN_P = 3;
	localparam int GAIN_D = 55;
	localparam int DRIVE_MAX = 128;
	localparam int DRIVE_MIN = -96;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] OFFSET_RESET =
		{8'd60, 8'd20, 8'd20, 8'd20, 8'd20, 8'd40};
	localparam logic [7:0] BASE_SPEED_RESET = 8'd101;

	typedef enum logic [2:0] {
		REG_OFFSET_ZERO  = 3'd0,
		REG_OFFSET_ONE   = 3'd1,
		REG_OFFSET_TWO   = 3'd2,
		REG_OFFSET_THREE = 3'd3,
		REG_OFFSET_FOUR  = 3'd4,
		REG_OFFSET_FIVE  = 3'd5,
		REG_BASE_SPEED   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_zero;
		logic [SAMPLE_W-1:0] sample_one;
		logic [SAMPLE_W-1:0] sample_two;
		logic [SAMPLE_W-1:0] sample_three;
		logic [SAMPLE_W-1:0] sample_four;
		logic [SAMPLE_W-1:0] sample_five;
	} sample_t;

	typedef struct packed {
		logic              left_reverse;
		logic [7:0]        left_duty;
		logic              right_reverse;
		logic [7:0]        right_duty;
		logic signed [POS_W-1:0] line_position;
		logic              line_lost;
		logic              line_end;
	} result_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic signed [MOM_W-1:0] moment;
		logic [SUM_W-1:0]        sum;
		logic                    lost;
		logic                    at_end;
	} job_t;

endpackage

`default_nettype wire

// ===== hdl/lfpd_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none

interface lfpd_chan_if #(parameter type data_t = logic) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfpd_front.sv =====
// Front end: offset, darkness, sum and centroid moment, line flags.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_front (
	input  wire logic clk,
	input  wire logic arst_n,
	lfpd_chan_if.sink samples,
	input  wire logic [lfpd_pkg::NUM_SENSORS-1:0][lfpd_pkg::SAMPLE_W-1:0] offsets,
	input  wire logic q_full,
	output lfpd_pkg::job_t job,
	output logic push
);
	import lfpd_pkg::*;

	logic [SAMPLE_W-1:0] samp [NUM_SENSORS];
	logic [SAMPLE_W-1:0] dark [NUM_SENSORS];
	logic [SAMPLE_W-1:0] dark_s1 [NUM_SENSORS];
	logic                valid_s1;
	logic [SAMPLE_W:0]   raw [NUM_SENSORS];
	logic signed [12:0]  wdark [NUM_SENSORS];
	logic signed [12:0]  acc;
	logic [SUM_W-1:0]    sum;

	always_comb begin
		samp[0] = samples.data.sample_zero;
		samp[1] = samples.data.sample_one;
		samp[2] = samples.data.sample_two;
		samp[3] = samples.data.sample_three;
		samp[4] = samples.data.sample_four;
		samp[5] = samples.data.sample_five;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			raw[i] = {1'b0, samp[i]} + {1'b0, offsets[i]};
			// A saturated reading is fully bright; otherwise darkness is 255 minus it.
			dark[i] = raw[i][SAMPLE_W] ? '0 : ~raw[i][SAMPLE_W-1:0];
		end
	end

	assign samples.ready = !valid_s1 || !q_full;
	assign push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			dark_s1 <= dark;
		end
	end

	// Weights are 16 times -5, -3, -1, 1, 3, 5, so the moment is a shifted sum.
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			sum = sum + SUM_W'(dark_s1[i]);
			wdark[i] = $signed({5'b0, dark_s1[i]});
		end
		acc = 13'sd5 * (wdark[5] - wdark[0]) + 13'sd3 * (wdark[4] - wdark[1])
			+ (wdark[3] - wdark[2]);
		job.moment = {acc, 4'b0000};
		job.sum = sum;
		job.lost = sum < SUM_W'(LOST_BELOW);
		job.at_end = sum > SUM_W'(END_ABOVE);
	end

endmodule

`default_nettype wire

// ===== hdl/lfpd_queue.sv =====
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_queue #(
	parameter int DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  lfpd_pkg::job_t wr_job,
	output logic full,
	input  wire logic pop,
	output lfpd_pkg::job_t rd_job,
	output logic empty
);
	import lfpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lfpd_back.sv =====
// Back end: serial divider for the position, PD steering and drive output register.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] base_speed,
	input  wire logic q_empty,
	input  lfpd_pkg::job_t q_job,
	output logic pop,
	lfpd_chan_if.source drive
);
	import lfpd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SIGN = 5'b00100,
		ST_MIX  = 5'b01000,
		ST_OUT  = 5'b10000
	} back_state_t;

	typedef struct packed {
		logic       reverse;
		logic [7:0] duty;
	} drive_t;

	localparam logic signed [16:0] DRV_MAX = 17'(DRIVE_MAX);
	localparam logic signed [16:0] DRV_MIN = 17'(DRIVE_MIN);

	back_state_t             state_q;
	logic [MAG_W-1:0]        num_q;
	logic [SUM_W-1:0]        rem_q;
	logic [SUM_W-1:0]        den_q;
	logic [3:0]              cnt_q;
	logic                    neg_q;
	logic                    lost_q;
	logic                    end_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] prev_q;
	logic signed [POS_W-1:0] last_good_q;
	logic signed [15:0]      steer_q;
	logic                    out_valid_q;
	result_t                 res_q;

	logic [SUM_W:0]          trial;
	logic                    fits;
	logic [MOM_W-1:0]        mag_full;
	logic [POS_W-1:0]        quot;
	logic signed [POS_W:0]   delta;
	logic signed [15:0]      steer;
	logic signed [16:0]      base_x;
	logic signed [16:0]      steer_x;
	drive_t                  left_d;
	drive_t                  right_d;
	logic                    out_free;

	function automatic drive_t drive_of(input logic signed [16:0] v);
		drive_t             d;
		logic signed [16:0] c;
		if (v < DRV_MIN) begin
			c = DRV_MIN;
		end else if (v > DRV_MAX) begin
			c = DRV_MAX;
		end else begin
			c = v;
		end
		d.reverse = c[16];
		d.duty = c[16] ? 8'(-c) : c[7:0];
		return d;
	endfunction

	// One quotient bit per cycle: shift the next numerator bit into the remainder.
	assign trial = {rem_q, num_q[MAG_W-1]};
	assign fits = trial >= {1'b0, den_q};
	assign mag_full = q_job.moment[MOM_W-1] ? -q_job.moment : q_job.moment;
	assign quot = num_q[POS_W-1:0];

	assign delta = $signed({pos_q[POS_W-1], pos_q}) - $signed({prev_q[POS_W-1], prev_q});
	assign steer = 16'(pos_q) * 16'sd3 + 16'(delta) * 16'sd55;
	assign base_x = $signed({9'b0, base_speed});
	assign steer_x = {steer_q[15], steer_q};
	assign left_d = drive_of(base_x + steer_x);
	assign right_d = drive_of(base_x - steer_x);

	assign out_free = !out_valid_q || drive.ready;
	assign pop = (state_q == ST_IDLE) && !q_empty;
	assign drive.valid = out_valid_q;
	assign drive.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			prev_q <= '0;
			last_good_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (drive.valid && drive.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_job.lost ? ST_MIX : ST_DIV;
						cnt_q <= 4'hF;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SIGN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SIGN: begin
					last_good_q <= neg_q ? -$signed(quot) : $signed(quot);
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					prev_q <= pos_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lost_q <= q_job.lost;
				end_q <= q_job.at_end;
				neg_q <= q_job.moment[MOM_W-1];
				num_q <= mag_full[MAG_W-1:0];
				den_q <= q_job.sum;
				rem_q <= '0;
				pos_q <= last_good_q;
			end
			ST_DIV: begin
				rem_q <= fits ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
				num_q <= {num_q[MAG_W-2:0], fits};
			end
			ST_SIGN: begin
				pos_q <= neg_q ? -$signed(quot) : $signed(quot);
			end
			ST_MIX: begin
				steer_q <= steer;
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.left_reverse <= left_d.reverse;
					res_q.left_duty <= left_d.duty;
					res_q.right_reverse <= right_d.reverse;
					res_q.right_duty <= right_d.duty;
					res_q.line_position <= pos_q;
					res_q.line_lost <= lost_q;
					res_q.line_end <= end_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/line_follower_pd_drive.sv =====
// Line follower PD drive: six sensor samples in, two motor drives and line flags out.
// The back end takes one item at a time into a restoring divider that makes one quotient
// bit per cycle; lost-line items skip the divider. The front stage and a short queue keep
// accepting samples while the divider works, until the queue is full.
// Reset clears the pipeline, the queue, the held positions and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module line_follower_pd_drive #(
	parameter int QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lfpd_chan_if.sink samples,
	lfpd_chan_if.source drive,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import lfpd_pkg::*;

	logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] offset_q;
	logic [7:0] base_speed_q;
	job_t       wr_job;
	job_t       rd_job;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			base_speed_q <= BASE_SPEED_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index)) inside
				[REG_OFFSET_ZERO:REG_OFFSET_FIVE]: offset_q[cfg_index] <= cfg_data;
				REG_BASE_SPEED: base_speed_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lfpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.offsets(offset_q),
		.q_full(q_full),
		.job(wr_job),
		.push(push)
	);

	lfpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.full(q_full),
		.pop(pop),
		.rd_job(rd_job),
		.empty(q_empty)
	);

	lfpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.base_speed(base_speed_q),
		.q_empty(q_empty),
		.q_job(rd_job),
		.pop(pop),
		.drive(drive)
	);

endmodule

`default_nettype wire

// ===== hdl/lfpd_checker.sv =====
// Port-level checks on the drive channel of the line follower PD drive.
`timescale 1ns / 1ps
`default_nettype none
`include "line_follower_pd_drive_assert.svh"

module lfpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic drive_valid,
	input wire logic drive_ready,
	input lfpd_pkg::result_t drive_data
);
	import lfpd_pkg::*;

	`LFPD_ASSERT_HOLD(a_drive_hold, clk, arst_n, drive_valid, drive_ready, drive_data)

	`LFPD_ASSERT(a_flags_excl, clk, arst_n, drive_valid |-> !(drive_data.line_lost && drive_data.line_end), "line lost and line end both set")

	`LFPD_ASSERT(a_left_range, clk, arst_n, drive_valid |-> (drive_data.left_reverse ? (drive_data.left_duty != 8'd0 && drive_data.left_duty <= 8'd96) : (drive_data.left_duty <= 8'd128)), "left drive outside clamp range")

	`LFPD_ASSERT(a_right_range, clk, arst_n, drive_valid |-> (drive_data.right_reverse ? (drive_data.right_duty != 8'd0 && drive_data.right_duty <= 8'd96) : (drive_data.right_duty <= 8'd128)), "right drive outside clamp range")

endmodule

bind line_follower_pd_drive lfpd_checker u_lfpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.drive_valid(drive.valid),
	.drive_ready(drive.ready),
	.drive_data(drive.data)
);

`default_nettype wire
